### rtl/life_generation_step_unit_defines.svh
// Assertion macros shared by the life generation step unit.
`ifndef LIFE_GENERATION_STEP_UNIT_DEFINES_SVH
`define LIFE_GENERATION_STEP_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define LGS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define LGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lgs_pkg.sv
// Shared types and constants of the life generation step unit.
package lgs_pkg;

   localparam int OPC_W     = 2;
   localparam int POS_W     = 6;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int NBR_W     = 4;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int MAX_COLS_DEFAULT = 64;
   localparam int MIN_SIZE         = 3;

   localparam logic [CFG_W-1:0] ROWS_RESET = 7'd30;
   localparam logic [CFG_W-1:0] COLS_RESET = 7'd50;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;
   localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;

   typedef enum logic [OPC_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_LOAD_FIRST,
      ST_LOAD_NEXT,
      ST_SWEEP,
      ST_WRITE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load_first;
      logic load_next;
      logic shift;
   } sweep_ctrl_type;

endpackage

### rtl/lgs_if.sv
// Channel interfaces of the life generation step unit: request, response, register write.
interface lgs_req_if;
   import lgs_pkg::*;

   logic             valid;
   logic             ready;
   logic [OPC_W-1:0] opcode;
   logic [POS_W-1:0] cell_row;
   logic [POS_W-1:0] cell_col;
   logic             alive_in;

   modport source (output valid, output opcode, output cell_row, output cell_col,
                   output alive_in, input ready);
   modport sink (input valid, input opcode, input cell_row, input cell_col,
                 input alive_in, output ready);
endinterface

interface lgs_rsp_if;
   logic valid;
   logic ready;
   logic alive_out;
   logic status;

   modport source (output valid, output alive_out, output status, input ready);
   modport sink (input valid, input alive_out, input status, output ready);
endinterface

interface lgs_csr_if;
   import lgs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/life_generation_step_unit.sv
// Top level of the life generation step unit: size registers, grid row memory, sequencer, sweep.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    opcode, cell_row, cell_col, alive_in
//   rsp_chan  out  valid/ready    alive_out, status
//   csr_chan  in   valid/ready    index, data (rows_in_use, cols_in_use)
//
// Cell read or write at an interior position: one grid row memory read, then modify.
// Border position, no-op, other opcodes: no grid row memory access, straight to the response.
// Generation: row by row, one cell per cycle through the rule unit.
// Reset clears per-row valid bits at once; the grid reads as all dead with no clearing pass.
// A stalled response holds in the output register; one more request is taken and holds its
// result until the register frees, and requests after it wait.
`include "life_generation_step_unit_defines.svh"

module life_generation_step_unit #(
   parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   lgs_req_if.sink   req_chan,
   lgs_rsp_if.source rsp_chan,
   lgs_csr_if.sink   csr_chan
);
   import lgs_pkg::*;

   localparam int RS_W = $clog2(MAX_ROWS + 1);
   localparam int CS_W = $clog2(MAX_COLS + 1);
   localparam int RA_W = $clog2(MAX_ROWS);
   localparam int RT_W = ((RS_W > CFG_W) ? RS_W : CFG_W) + 1;
   localparam int CT_W = ((CS_W > CFG_W) ? CS_W : CFG_W) + 1;

   logic [CFG_W-1:0]    rows_ff, rows_in;
   logic [CFG_W-1:0]    cols_ff, cols_in;
   logic [RS_W-1:0]     nr;
   logic [CS_W-1:0]     nc;
   logic                ram_wr_en;
   logic [RA_W-1:0]     ram_wr_addr;
   logic [MAX_COLS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [RA_W-1:0]     ram_rd_addr;
   logic [MAX_COLS-1:0] ram_rd_data;
   sweep_ctrl_type      sweep_ctrl;
   logic                below_border;
   logic [MAX_COLS-1:0] raw_row;
   logic [MAX_COLS-1:0] res_row;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ROWS: rows_in = csr_chan.data;
            CSR_COLS: cols_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // clamp sizes to the legal range
   always_comb begin
      if (RT_W'(rows_ff) < RT_W'(MIN_SIZE)) begin
         nr = RS_W'(MIN_SIZE);
      end else if (RT_W'(rows_ff) > RT_W'(MAX_ROWS)) begin
         nr = RS_W'(MAX_ROWS);
      end else begin
         nr = RS_W'(rows_ff);
      end
      if (CT_W'(cols_ff) < CT_W'(MIN_SIZE)) begin
         nc = CS_W'(MIN_SIZE);
      end else if (CT_W'(cols_ff) > CT_W'(MAX_COLS)) begin
         nc = CS_W'(MAX_COLS);
      end else begin
         nc = CS_W'(cols_ff);
      end
   end

   lgs_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lgs_sweep #(
      .MAX_COLS (MAX_COLS)
   ) u_sweep (
      .clock        (clock),
      .ctrl         (sweep_ctrl),
      .raw_row      (raw_row),
      .below_border (below_border),
      .nc           (nc),
      .res_row      (res_row)
   );

   lgs_seq #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .nr           (nr),
      .nc           (nc),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .sweep_ctrl   (sweep_ctrl),
      .below_border (below_border),
      .raw_row      (raw_row),
      .res_row      (res_row)
   );

   `LGS_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while previous one in progress")
   `LGS_ASSERT_SAME(a_no_row_collide, clock, reset, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "grid row read and written in same cycle")
   `LGS_ASSERT_SAME(a_size_range, clock, reset, 1'b1, (nr >= RS_W'(MIN_SIZE)) && (nr <= RS_W'(MAX_ROWS)) && (nc >= CS_W'(MIN_SIZE)) && (nc <= CS_W'(MAX_COLS)), "grid size out of range")

endmodule

### rtl/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lgs_sweep.sv
// Row sweep datapath: three-row window shift lines and the shared neighbor count and rule unit.
module lgs_sweep #(
   parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEFAULT,
   localparam int CS_W = $clog2(MAX_COLS + 1)
) (
   input  logic                   clock,
   input  lgs_pkg::sweep_ctrl_type ctrl,
   input  logic [MAX_COLS-1:0]    raw_row,
   input  logic                   below_border,
   input  logic [CS_W-1:0]        nc,
   output logic [MAX_COLS-1:0]    res_row
);
   import lgs_pkg::*;

   localparam int WW = MAX_COLS + 2;

   logic [MAX_COLS-1:0] col_mask;
   logic [MAX_COLS-1:0] prev_ff, prev_in;
   logic [MAX_COLS-1:0] cur_ff, cur_in;
   logic [WW-1:0]       win_p_ff, win_p_in;
   logic [WW-1:0]       win_c_ff, win_c_in;
   logic [WW-1:0]       win_n_ff, win_n_in;
   logic [MAX_COLS-1:0] raw_sh_ff, raw_sh_in;
   logic [MAX_COLS-1:0] mask_sh_ff, mask_sh_in;
   logic [MAX_COLS-1:0] res_ff, res_in;
   logic [NBR_W-1:0]    nbr_count;
   logic                self_alive;
   logic                cell_next;

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
      assign col_mask[c] = (c != 0) && (CS_W'(c + 1) < nc);
   end

   assign nbr_count = NBR_W'(win_p_ff[0]) + NBR_W'(win_p_ff[1]) + NBR_W'(win_p_ff[2])
                    + NBR_W'(win_c_ff[0]) + NBR_W'(win_c_ff[2])
                    + NBR_W'(win_n_ff[0]) + NBR_W'(win_n_ff[1]) + NBR_W'(win_n_ff[2]);
   assign self_alive = win_c_ff[1];

   always_comb begin
      if (mask_sh_ff[0]) begin
         cell_next = (nbr_count == BIRTH_COUNT) || (self_alive && (nbr_count == SURVIVE_COUNT));
      end else begin
         cell_next = raw_sh_ff[0];
      end
   end

   always_comb begin
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      win_p_in   = win_p_ff;
      win_c_in   = win_c_ff;
      win_n_in   = win_n_ff;
      raw_sh_in  = raw_sh_ff;
      mask_sh_in = mask_sh_ff;
      res_in     = res_ff;
      if (ctrl.load_first) begin
         prev_in = '0;
         cur_in  = raw_row;
      end
      if (ctrl.load_next) begin
         win_p_in   = {1'b0, prev_ff, 1'b0};
         win_c_in   = {1'b0, cur_ff & col_mask, 1'b0};
         win_n_in   = below_border ? '0 : {1'b0, raw_row & col_mask, 1'b0};
         prev_in    = cur_ff & col_mask;
         raw_sh_in  = cur_ff;
         mask_sh_in = col_mask;
         cur_in     = raw_row;
      end
      if (ctrl.shift) begin
         win_p_in   = {1'b0, win_p_ff[WW-1:1]};
         win_c_in   = {1'b0, win_c_ff[WW-1:1]};
         win_n_in   = {1'b0, win_n_ff[WW-1:1]};
         raw_sh_in  = {1'b0, raw_sh_ff[MAX_COLS-1:1]};
         mask_sh_in = {1'b0, mask_sh_ff[MAX_COLS-1:1]};
         res_in     = {cell_next, res_ff[MAX_COLS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      win_p_ff   <= win_p_in;
      win_c_ff   <= win_c_in;
      win_n_ff   <= win_n_in;
      raw_sh_ff  <= raw_sh_in;
      mask_sh_ff <= mask_sh_in;
      res_ff     <= res_in;
   end

   assign res_row = res_ff;

endmodule

### rtl/lgs_seq.sv
// Sequencer: request decode, cell read-modify-write, generation row loop, response register.
module lgs_seq #(
   parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEFAULT,
   localparam int RS_W = $clog2(MAX_ROWS + 1),
   localparam int CS_W = $clog2(MAX_COLS + 1),
   localparam int RA_W = $clog2(MAX_ROWS),
   localparam int CA_W = $clog2(MAX_COLS)
) (
   input  logic                    clock,
   input  logic                    reset,
   lgs_req_if.sink                 req,
   lgs_rsp_if.source               rsp,
   input  logic [RS_W-1:0]         nr,
   input  logic [CS_W-1:0]         nc,
   output logic                    ram_wr_en,
   output logic [RA_W-1:0]         ram_wr_addr,
   output logic [MAX_COLS-1:0]     ram_wr_data,
   output logic                    ram_rd_en,
   output logic [RA_W-1:0]         ram_rd_addr,
   input  logic [MAX_COLS-1:0]     ram_rd_data,
   output lgs_pkg::sweep_ctrl_type sweep_ctrl,
   output logic                    below_border,
   output logic [MAX_COLS-1:0]     raw_row,
   input  logic [MAX_COLS-1:0]     res_row
);
   import lgs_pkg::*;

   localparam int W1    = (RS_W > CS_W) ? RS_W : CS_W;
   localparam int CMP_W = ((W1 > POS_W) ? W1 : POS_W) + 1;

   state_type           state_ff, state_in;
   logic [OPC_W-1:0]    op_ff, op_in;
   logic [RA_W-1:0]     row_ff, row_in;
   logic [CA_W-1:0]     col_ff, col_in;
   logic                alive_ff, alive_in;
   logic                res_alive_ff, res_alive_in;
   logic                res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_alive_ff, rsp_alive_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [MAX_ROWS-1:0] row_valid_ff, row_valid_in;

   logic                req_xfer;
   logic                rsp_free;
   logic                interior;
   logic                cell_op;
   logic                last_row;
   logic                sweep_done;
   logic [CMP_W-1:0]    r_ext, c_ext, nr_ext, nc_ext;
   logic [CMP_W-1:0]    row_p1, row_p2;
   logic [MAX_COLS-1:0] mod_row;

   assign req_xfer = req.valid && req.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   assign r_ext    = CMP_W'(req.cell_row);
   assign c_ext    = CMP_W'(req.cell_col);
   assign nr_ext   = CMP_W'(nr);
   assign nc_ext   = CMP_W'(nc);
   assign interior = (r_ext != '0) && ((r_ext + CMP_W'(1)) < nr_ext)
                  && (c_ext != '0) && ((c_ext + CMP_W'(1)) < nc_ext);
   assign cell_op  = (req.opcode == OP_WRITE) || (req.opcode == OP_READ);

   assign row_p1     = CMP_W'(row_ff) + CMP_W'(1);
   assign row_p2     = CMP_W'(row_ff) + CMP_W'(2);
   assign last_row   = row_p2 >= nr_ext;
   assign sweep_done = col_ff == CA_W'(MAX_COLS - 1);

   assign raw_row = rd_vld_ff ? ram_rd_data : '0;

   always_comb begin
      mod_row         = raw_row;
      mod_row[col_ff] = alive_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req.opcode) inside
                  OP_WRITE, OP_READ: state_in = interior ? ST_MODIFY : ST_RESPOND;
                  OP_STEP:           state_in = ST_LOAD_FIRST;
                  default:           state_in = ST_RESPOND;
               endcase
            end
         end
         ST_MODIFY:     state_in = ST_RESPOND;
         ST_LOAD_FIRST: state_in = ST_LOAD_NEXT;
         ST_LOAD_NEXT:  state_in = ST_SWEEP;
         ST_SWEEP:      state_in = sweep_done ? ST_WRITE : ST_SWEEP;
         ST_WRITE:      state_in = last_row ? ST_RESPOND : ST_LOAD_NEXT;
         ST_RESPOND:    state_in = rsp_free ? ST_IDLE : ST_RESPOND;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = row_ff;
      ram_wr_data  = res_row;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = row_ff;
      sweep_ctrl   = '0;
      below_border = last_row;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.opcode == OP_STEP) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = RA_W'(1);
               end else if (cell_op && interior) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = RA_W'(req.cell_row);
               end
            end
         end
         ST_MODIFY: begin
            ram_wr_en   = op_ff == OP_WRITE;
            ram_wr_data = mod_row;
         end
         ST_LOAD_FIRST: begin
            sweep_ctrl.load_first = 1'b1;
            ram_rd_en             = 1'b1;
            ram_rd_addr           = row_p1[RA_W-1:0];
         end
         ST_LOAD_NEXT: sweep_ctrl.load_next = 1'b1;
         ST_SWEEP:     sweep_ctrl.shift = 1'b1;
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            if (!last_row) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = row_p2[RA_W-1:0];
            end
         end
         ST_RESPOND: ;
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      op_in         = op_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      alive_in      = alive_ff;
      res_alive_in  = res_alive_ff;
      res_status_in = res_status_ff;
      rsp_alive_in  = rsp_alive_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      row_valid_in  = row_valid_ff;
      rd_vld_in     = ram_rd_en ? row_valid_ff[ram_rd_addr] : rd_vld_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ram_wr_en) begin
         row_valid_in[ram_wr_addr] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in         = req.opcode;
               row_in        = (req.opcode == OP_STEP) ? RA_W'(1) : RA_W'(req.cell_row);
               col_in        = CA_W'(req.cell_col);
               alive_in      = req.alive_in;
               res_alive_in  = 1'b0;
               res_status_in = cell_op && !interior;
            end
         end
         ST_MODIFY: begin
            if (op_ff == OP_READ) begin
               res_alive_in = raw_row[col_ff];
            end
         end
         ST_LOAD_NEXT: col_in = '0;
         ST_SWEEP:     col_in = col_ff + CA_W'(1);
         ST_WRITE:     row_in = row_p1[RA_W-1:0];
         ST_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_alive_in  = res_alive_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      alive_ff      <= alive_in;
      res_alive_ff  <= res_alive_in;
      res_status_ff <= res_status_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.alive_out = rsp_alive_ff;
   assign rsp.status    = rsp_status_ff;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the life generation step unit: random and directed cell traffic.
`timescale 1ns / 100ps

module testbench;
   import lgs_pkg::*;

   localparam logic [OPC_W-1:0] OP_NONE = 2'd3;
   localparam int GRID_ROWS = MAX_ROWS_DEFAULT;
   localparam int GRID_COLS = MAX_COLS_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 152;

   typedef struct {
      logic [OPC_W-1:0] opcode;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             alive;
   } cell_request_type;

   typedef struct {
      logic alive_out;
      logic status;
   } cell_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lgs_req_if req_if ();
   lgs_rsp_if rsp_if ();
   lgs_csr_if csr_if ();

   life_generation_step_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit               grid [GRID_ROWS][GRID_COLS];
   logic [CFG_W-1:0] rows_reg = ROWS_RESET;
   logic [CFG_W-1:0] cols_reg = COLS_RESET;

   cell_request_type cell_requests [$];
   cell_reply_type   cell_replies [$];
   cell_request_type offered;
   bit               in_hand = 1'b0;
   int               failures = 0;
   int               replies_seen = 0;

   function automatic int clamp_size(logic [CFG_W-1:0] v, int top);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > top) return top;
      return v;
   endfunction

   function automatic bit is_inner(int r, int c);
      int nr;
      int nc;
      nr = clamp_size(rows_reg, GRID_ROWS);
      nc = clamp_size(cols_reg, GRID_COLS);
      return r >= 1 && r + 1 < nr && c >= 1 && c + 1 < nc;
   endfunction

   function automatic int live_at(int r, int c);
      if (!is_inner(r, c)) return 0;
      return grid[r][c];
   endfunction

   function automatic void advance_generation();
      bit next_grid [GRID_ROWS][GRID_COLS];
      int nr;
      int nc;
      int n;
      nr = clamp_size(rows_reg, GRID_ROWS);
      nc = clamp_size(cols_reg, GRID_COLS);
      next_grid = grid;
      for (int r = 1; r + 1 < nr; r++) begin
         for (int c = 1; c + 1 < nc; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0) n += live_at(r + dr, c + dc);
            if (grid[r][c]) next_grid[r][c] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
            else next_grid[r][c] = (n == BIRTH_COUNT);
         end
      end
      grid = next_grid;
   endfunction

   function automatic cell_reply_type life_apply(cell_request_type q);
      cell_reply_type a;
      a.alive_out = 1'b0;
      a.status = 1'b0;
      if (q.opcode == OP_WRITE) begin
         if (is_inner(q.row, q.col)) grid[q.row][q.col] = q.alive;
         else a.status = 1'b1;
      end else if (q.opcode == OP_READ) begin
         if (is_inner(q.row, q.col)) a.alive_out = grid[q.row][q.col];
         else a.status = 1'b1;
      end else if (q.opcode == OP_STEP) begin
         advance_generation();
      end
      return a;
   endfunction

   function automatic int pick_pause(ref int calm);
      int k;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      k = $urandom_range(0, 99);
      if (k < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request driver and predictor.
   int req_idle = 0;
   int req_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            cell_replies.push_back(life_apply(offered));
            in_hand = 1'b0;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_idle > 0) begin
               req_idle--;
               req_if.valid <= 1'b0;
            end else if (cell_requests.size() > 0) begin
               offered = cell_requests.pop_front();
               in_hand = 1'b1;
               req_if.valid    <= 1'b1;
               req_if.opcode   <= offered.opcode;
               req_if.cell_row <= offered.row;
               req_if.cell_col <= offered.col;
               req_if.alive_in <= offered.alive;
               req_idle = pick_pause(req_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure, with one long hold-off to fill the block.
   int rsp_stall = 0;
   int rsp_calm = 0;
   int hold_left = 0;
   bit pressure_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (!pressure_done && replies_seen >= 300) begin
            hold_left = 400;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_stall = pick_pause(rsp_calm);
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      cell_reply_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         replies_seen++;
         if (cell_replies.size() == 0) begin
            $display("%0t: unexpected transfer: alive_out %0b status %0b", $time,
                     rsp_if.alive_out, rsp_if.status);
            failures++;
         end else begin
            want = cell_replies.pop_front();
            if (rsp_if.alive_out !== want.alive_out) begin
               $display("%0t: alive_out expected %0b actual %0b", $time, want.alive_out,
                        rsp_if.alive_out);
               failures++;
            end
            if (rsp_if.status !== want.status) begin
               $display("%0t: status expected %0b actual %0b", $time, want.status,
                        rsp_if.status);
               failures++;
            end
         end
      end
   end

   task automatic write_size(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_ROWS) rows_reg = value;
      else cols_reg = value;
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (cell_requests.size() != 0 || cell_replies.size() != 0 || in_hand)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_cell(input logic [OPC_W-1:0] op, input int r, input int c,
                             input bit a);
      cell_request_type q;
      q.opcode = op;
      q.row = POS_W'(r);
      q.col = POS_W'(c);
      q.alive = a;
      cell_requests.push_back(q);
   endtask

   function automatic int random_position(int n);
      int k;
      k = $urandom_range(0, 99);
      if (k < 85) return $urandom_range(1, n - 2);
      if (k < 93) return ($urandom_range(0, 1) != 0) ? n - 1 : 0;
      return $urandom_range(0, 63);
   endfunction

   initial begin
      int fixed_rows [6];
      int fixed_cols [6];
      logic [CFG_W-1:0] rows_pick;
      logic [CFG_W-1:0] cols_pick;
      int nr;
      int nc;
      int step_pct;
      int k;

      fixed_rows = '{3, 64, 3, 127, 0, 65};
      fixed_cols = '{3, 3, 64, 2, 127, 10};

      req_if.valid    = 1'b0;
      req_if.opcode   = OP_WRITE;
      req_if.cell_row = '0;
      req_if.cell_col = '0;
      req_if.alive_in = 1'b0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_ROWS;
      csr_if.data     = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_cell(OP_READ, 0, 0, 1'b1);
      queue_cell(OP_WRITE, 1, 1, 1'b1);
      queue_cell(OP_READ, 1, 1, 1'b0);
      queue_cell(OP_WRITE, 28, 48, 1'b1);
      queue_cell(OP_READ, 28, 48, 1'b0);
      queue_cell(OP_WRITE, 29, 49, 1'b1);
      queue_cell(OP_WRITE, 0, 10, 1'b1);
      queue_cell(OP_WRITE, 63, 63, 1'b1);
      queue_cell(OP_READ, 63, 63, 1'b1);
      queue_cell(OP_READ, 29, 49, 1'b0);
      queue_cell(OP_NONE, 63, 63, 1'b1);
      queue_cell(OP_WRITE, 5, 5, 1'b1);
      queue_cell(OP_WRITE, 5, 6, 1'b1);
      queue_cell(OP_WRITE, 5, 7, 1'b1);
      queue_cell(OP_STEP, 63, 63, 1'b1);
      queue_cell(OP_READ, 4, 6, 1'b0);
      queue_cell(OP_READ, 5, 6, 1'b0);
      queue_cell(OP_READ, 6, 6, 1'b0);
      queue_cell(OP_READ, 5, 5, 1'b0);
      queue_cell(OP_WRITE, 1, 1, 1'b0);
      queue_cell(OP_READ, 1, 1, 1'b0);
      queue_cell(OP_STEP, 0, 0, 1'b0);
      queue_cell(OP_READ, 5, 6, 1'b0);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 6) begin
            rows_pick = CFG_W'(fixed_rows[p]);
            cols_pick = CFG_W'(fixed_cols[p]);
         end else if ($urandom_range(0, 99) < 80) begin
            rows_pick = CFG_W'($urandom_range(3, 14));
            cols_pick = CFG_W'($urandom_range(3, 14));
         end else begin
            rows_pick = CFG_W'($urandom_range(0, 127));
            cols_pick = CFG_W'($urandom_range(0, 127));
         end
         write_size(CSR_ROWS, rows_pick);
         write_size(CSR_COLS, cols_pick);
         nr = clamp_size(rows_reg, GRID_ROWS);
         nc = clamp_size(cols_reg, GRID_COLS);
         step_pct = (nr > 20) ? 2 : 8;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            k = $urandom_range(0, 99);
            if (k < step_pct)
               queue_cell(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
            else if (k < step_pct + 2)
               queue_cell(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
            else if (k < step_pct + 50)
               queue_cell(OP_WRITE, random_position(nr), random_position(nc),
                          1'($urandom_range(0, 1)));
            else
               queue_cell(OP_READ, random_position(nr), random_position(nc),
                          1'($urandom_range(0, 1)));
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (failures == 0 && cell_replies.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #(30_000_000);
      $display("testbench: FAIL");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/lgs_pkg.sv
rtl/lgs_if.sv
rtl/lgs_ram.sv
rtl/lgs_sweep.sv
rtl/lgs_seq.sv
rtl/life_generation_step_unit.sv
tb/sv/testbench.sv
